### rtl/rlb_pkg.sv
// ----------------------------------------------------------------------------
// rlb_pkg
// Shared types and constants for the resonant lowpass biquad.
// ----------------------------------------------------------------------------
package rlb_pkg;

    // Recursive state values are signed Q15.16 words
    localparam int STATE_W = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2 = 2'd2;

    // Recursive values needed to form one output sample
    typedef struct packed {
        logic signed [STATE_W-1:0] recent;   // newest recursive value
        logic signed [STATE_W-1:0] older;    // one before it
        logic signed [STATE_W-1:0] oldest;   // two before it
    } rlb_taps_t;

endpackage

### rtl/rlb_gain.sv
// ----------------------------------------------------------------------------
// rlb_gain
// Input register and input gain stage: registers the sample, then a0 * x.
// ----------------------------------------------------------------------------
module rlb_gain
    import rlb_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_W      = 20
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       in_sample,
    input  logic signed [COEF_W-1:0]            coef_a0,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS+COEF_W-1:0] out_ax
);

    localparam int AX_W = SAMPLE_BITS + COEF_W;

    logic                          x_valid_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          ax_valid_reg;
    logic signed [AX_W-1:0]        ax_reg;
    logic signed [AX_W-1:0]        ax_next;
    logic                          ax_load;
    logic                          x_load;

    // Stage enables: a stage loads when empty or when it drains downstream
    assign ax_load  = !ax_valid_reg || out_ready;
    assign x_load   = !x_valid_reg || ax_load;
    assign in_ready = x_load;

    // Exact product, Q.F fractional bits
    assign ax_next = coef_a0 * x_reg;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_valid_reg  <= 1'b0;
            ax_valid_reg <= 1'b0;
        end else begin
            if (x_load) begin
                x_valid_reg <= in_valid;
            end
            if (ax_load) begin
                ax_valid_reg <= x_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (x_load && in_valid) begin
            x_reg <= in_sample;
        end
        if (ax_load && x_valid_reg) begin
            ax_reg <= ax_next;
        end
    end

    assign out_valid = ax_valid_reg;
    assign out_ax    = ax_reg;

endmodule

### rtl/rlb_recur.sv
// ----------------------------------------------------------------------------
// rlb_recur
// Recursive section: y0 = a0*x + round(b1*y1 + b2*y2), saturated to 32 bits,
// and the state line of the newest value and the two before it.
// ----------------------------------------------------------------------------
module rlb_recur
    import rlb_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         in_valid,
    output logic                                         in_ready,
    input  logic signed [SAMPLE_BITS+COEF_FRAC_BITS+3:0] in_ax,
    input  logic signed [COEF_FRAC_BITS+3:0]             coef_b1,
    input  logic signed [COEF_FRAC_BITS+3:0]             coef_b2,
    output logic                                         out_valid,
    input  logic                                         out_ready,
    output rlb_taps_t                                    out_taps
);

    localparam int CW     = COEF_FRAC_BITS + 4;
    localparam int AX_W   = SAMPLE_BITS + CW;
    localparam int PROD_W = CW + STATE_W;
    localparam int FB_W   = PROD_W + 1;
    localparam int ACC_W  = ((FB_W > AX_W) ? FB_W : AX_W) + 1;

    localparam logic signed [ACC_W-1:0] ST_MAX =
        {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ST_MIN =
        {{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
    localparam logic signed [FB_W-1:0] FB_HALF =
        {{(FB_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

    logic                      valid_reg;
    logic signed [STATE_W-1:0] recent_reg;
    logic signed [STATE_W-1:0] older_reg;
    logic signed [STATE_W-1:0] oldest_reg;
    logic signed [STATE_W-1:0] y0_next;
    logic signed [PROD_W-1:0]  prod1;
    logic signed [PROD_W-1:0]  prod2;
    logic signed [FB_W-1:0]    fb;
    logic signed [FB_W-1:0]    fb_rnd;
    logic signed [FB_W-1:0]    fb_sh;
    logic signed [ACC_W-1:0]   acc;
    logic                      load;
    logic                      step;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;
    assign step     = load && in_valid;

    // Feedback sum, round half up to F fractional bits
    assign prod1  = coef_b1 * recent_reg;
    assign prod2  = coef_b2 * older_reg;
    assign fb     = FB_W'(prod1) + FB_W'(prod2);
    assign fb_rnd = fb + FB_HALF;
    assign fb_sh  = fb_rnd >>> COEF_FRAC_BITS;
    assign acc    = ACC_W'(fb_sh) + ACC_W'(in_ax);

    // Saturate to the state range
    always_comb begin
        priority if (acc > ST_MAX) begin
            y0_next = ST_MAX[STATE_W-1:0];
        end else if (acc < ST_MIN) begin
            y0_next = ST_MIN[STATE_W-1:0];
        end else begin
            y0_next = acc[STATE_W-1:0];
        end
    end

    // State line and valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            recent_reg <= '0;
            older_reg  <= '0;
        end else begin
            if (load) begin
                valid_reg <= in_valid;
            end
            if (step) begin
                recent_reg <= y0_next;
                older_reg  <= recent_reg;
            end
        end
    end

    // Value two back, only needed by the output sum
    always_ff @(posedge aclk) begin
        if (step) begin
            oldest_reg <= older_reg;
        end
    end

    assign out_valid       = valid_reg;
    assign out_taps.recent = recent_reg;
    assign out_taps.older  = older_reg;
    assign out_taps.oldest = oldest_reg;

endmodule

### rtl/rlb_outsat.sv
// ----------------------------------------------------------------------------
// rlb_outsat
// Output stage: y0 + 2*y1 + y2, rounded to an integer, saturated, registered.
// ----------------------------------------------------------------------------
module rlb_outsat
    import rlb_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rlb_taps_t                     in_taps,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);

    localparam int SUM_W = STATE_W + 3;
    localparam int CMP_W = (SUM_W > SAMPLE_BITS + 1) ? SUM_W : SAMPLE_BITS + 1;

    localparam logic signed [CMP_W-1:0] S_MAX =
        {{(CMP_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [CMP_W-1:0] S_MIN =
        {{(CMP_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_HALF =
        {{(SUM_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] sample_next;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SUM_W-1:0]       sum_rnd;
    logic signed [SUM_W-1:0]       sum_sh;
    logic signed [CMP_W-1:0]       sum_ext;
    logic                          load;

    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // Fixed (1 + z^-1)^2 numerator
    assign sum     = SUM_W'(in_taps.recent) + (SUM_W'(in_taps.older) <<< 1)
                   + SUM_W'(in_taps.oldest);
    assign sum_rnd = sum + SUM_HALF;
    assign sum_sh  = sum_rnd >>> COEF_FRAC_BITS;
    assign sum_ext = CMP_W'(sum_sh);

    // Saturate to the sample range
    always_comb begin
        priority if (sum_ext > S_MAX) begin
            sample_next = S_MAX[SAMPLE_BITS-1:0];
        end else if (sum_ext < S_MIN) begin
            sample_next = S_MIN[SAMPLE_BITS-1:0];
        end else begin
            sample_next = sum_ext[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && in_valid) begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_sample = sample_reg;

endmodule

### rtl/resonant_lowpass_biquad.sv
// ----------------------------------------------------------------------------
// resonant_lowpass_biquad
// Two-pole resonant lowpass with a fixed (1 + z^-1)^2 numerator and
// programmable a0, b1, b2 coefficients in signed Q3.F.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                  Direction  Content
//  s_       s_valid, s_ready, s_sample_in          in         one audio sample
//  m_       m_valid, m_ready, m_sample_out         out        one filtered sample
//  cfg_     cfg_valid, cfg_ready, cfg_index,       in         coefficient write
//           cfg_data
//
//  One sample per clock while m_ready is high. Four register stages (input,
//  a0*x product, recursive state, output). The loop through b1*y1 + b2*y2,
//  rounding and saturation back into the state registers is combinational and
//  sets the throughput. Synchronous reset clears the coefficients, the newest
//  and older state values (not the oldest) and all valid bits.
//  A stall on m_ready backs up stage by stage; s_ready drops once every stage
//  holds an item. cfg_ready is always high.
//
module resonant_lowpass_biquad
    import rlb_pkg::*;
#(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_BITS-1:0]  s_sample_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_BITS-1:0]  m_sample_out,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [COEF_FRAC_BITS+3:0]      cfg_data
);

    localparam int CW   = COEF_FRAC_BITS + 4;
    localparam int AX_W = SAMPLE_BITS + CW;

    logic signed [CW-1:0]   coef_a0_reg;
    logic signed [CW-1:0]   coef_b1_reg;
    logic signed [CW-1:0]   coef_b2_reg;
    logic                   ax_valid;
    logic                   ax_ready;
    logic signed [AX_W-1:0] ax;
    logic                   taps_valid;
    logic                   taps_ready;
    rlb_taps_t              taps;

    // Coefficient registers; unused index is ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_a0_reg <= '0;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_COEF_A0: begin
                    coef_a0_reg <= cfg_data;
                end
                CFG_COEF_B1: begin
                    coef_b1_reg <= cfg_data;
                end
                CFG_COEF_B2: begin
                    coef_b2_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register and a0 * x
    rlb_gain #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_W      (CW)
    ) u_gain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sample (s_sample_in),
        .coef_a0   (coef_a0_reg),
        .out_valid (ax_valid),
        .out_ready (ax_ready),
        .out_ax    (ax)
    );

    // Recursive section and state
    rlb_recur #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_recur (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ax_valid),
        .in_ready  (ax_ready),
        .in_ax     (ax),
        .coef_b1   (coef_b1_reg),
        .coef_b2   (coef_b2_reg),
        .out_valid (taps_valid),
        .out_ready (taps_ready),
        .out_taps  (taps)
    );

    // Numerator, rounding and output saturation
    rlb_outsat #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_outsat (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (taps_valid),
        .in_ready   (taps_ready),
        .in_taps    (taps),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_sample (m_sample_out)
    );

endmodule

### test/resonant_lowpass_biquad_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resonant_lowpass_biquad_tb
// Self-checking bench for the two-pole resonant lowpass. A bit-exact model
// of the recursion and the (1 + z^-1)^2 output sum predicts every sample.
// Directed items cover the rounding and saturation corners, then random
// coefficient sets drive random audio under three back-pressure mixes.
// ----------------------------------------------------------------------------
module resonant_lowpass_biquad_tb;
    import rlb_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int FRAC_W   = 16;
    localparam int COEF_W   = FRAC_W + 4;

    // Index with no register behind it; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_W - 1);
    localparam longint STATE_MAX  = 64'sd2147483647;
    localparam longint STATE_MIN  = -64'sd2147483648;
    localparam longint OUT_MAX    = 64'sd32767;
    localparam longint OUT_MIN    = -64'sd32768;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [COEF_W-1:0]   COEF_MAX   = 20'sh7FFFF;
    localparam logic signed [COEF_W-1:0]   COEF_MIN   = 20'sh80000;
    localparam logic signed [COEF_W-1:0]   COEF_ONE   = 20'sd65536;
    localparam logic signed [COEF_W-1:0]   COEF_HALF  = 20'sd32768;
    localparam logic signed [COEF_W-1:0]   EDGE_COEFS [7] = '{
        COEF_MAX, COEF_MIN, 20'sd0, COEF_ONE, -COEF_ONE, 20'sd1, -20'sd1
    };

    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;

    // DUT ports
    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in  = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       cfg_valid    = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [COEF_W-1:0]          cfg_data     = '0;

    // Predictor copy of the coefficients and the recursive state
    logic signed [COEF_W-1:0]   gain_a0  = '0;
    logic signed [COEF_W-1:0]   fb_b1    = '0;
    logic signed [COEF_W-1:0]   fb_b2    = '0;
    logic signed [31:0]         recent_y = '0;
    logic signed [31:0]         older_y  = '0;

    logic signed [SAMPLE_W-1:0] expected_outputs [$];

    int send_idle_pct  = 33;
    int recv_stall_pct = 68;
    int error_count    = 0;
    int cycle_count    = 0;

    resonant_lowpass_biquad #(
        .SAMPLE_BITS    (SAMPLE_W),
        .COEF_FRAC_BITS (FRAC_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("resonant_lowpass_biquad regression: fail");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // One filter step: advances the state and returns the output sample
    function automatic logic signed [SAMPLE_W-1:0] lowpass_next_sample(
            input logic signed [SAMPLE_W-1:0] x);
        longint feedback;
        longint y0;
        longint total;
        longint rounded;
        feedback = longint'(fb_b1) * longint'(recent_y)
                 + longint'(fb_b2) * longint'(older_y);
        // feedback rounds half up to Q.16, then the input term joins exactly
        y0 = ((feedback + ROUND_HALF) >>> FRAC_W) + longint'(gain_a0) * longint'(x);
        if (y0 > STATE_MAX) y0 = STATE_MAX;
        else if (y0 < STATE_MIN) y0 = STATE_MIN;
        // fixed numerator 1 + 2z^-1 + z^-2, then round and saturate
        total   = y0 + 2 * longint'(recent_y) + longint'(older_y);
        rounded = (total + ROUND_HALF) >>> FRAC_W;
        if (rounded > OUT_MAX) rounded = OUT_MAX;
        else if (rounded < OUT_MIN) rounded = OUT_MIN;
        older_y  = recent_y;
        recent_y = y0[31:0];
        return rounded[SAMPLE_W-1:0];
    endfunction

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%s", msg);
    endtask

    // Output checker
    always @(posedge aclk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                log_error($sformatf("unexpected sample_out item: %0d", m_sample_out));
            end else begin
                want = expected_outputs.pop_front();
                if (m_sample_out !== want)
                    log_error($sformatf("sample_out mismatch: expected %0d, got %0d",
                                        want, m_sample_out));
            end
        end
    end

    // Send one sample, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= value;
        do @(posedge aclk); while (!s_ready);
        expected_outputs.push_back(lowpass_next_sample(value));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_outputs.size() != 0) @(posedge aclk);
    endtask

    // One register write; caller drops cfg_valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_COEF_A0: gain_a0 = value;
            CFG_COEF_B1: fb_b1   = value;
            CFG_COEF_B2: fb_b2   = value;
            default: ;
        endcase
    endtask

    // Load a coefficient set while the pipeline is empty
    task automatic set_coefs(input logic signed [COEF_W-1:0] a0,
                             input logic signed [COEF_W-1:0] b1,
                             input logic signed [COEF_W-1:0] b2,
                             input bit with_unused);
        wait_drained();
        if (with_unused) write_reg(CFG_UNUSED, COEF_W'($urandom()));
        write_reg(CFG_COEF_A0, a0);
        write_reg(CFG_COEF_B1, b1);
        write_reg(CFG_COEF_B2, b2);
        cfg_valid <= 1'b0;
    endtask

    // Coefficients are zero out of reset, so everything filters to silence
    task automatic test_reset_defaults();
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
    endtask

    // Unity gain, no feedback: output is x + 2x' + x'', saturating both ways
    task automatic test_unity_numerator();
        set_coefs(COEF_ONE, '0, '0, 1'b0);
        repeat (3) send_sample(SAMPLE_MIN);
        repeat (3) send_sample(SAMPLE_MAX);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd0);
    endtask

    // Half gain on +/-1 lands exactly on .5; rounding is half up
    task automatic test_half_rounding();
        set_coefs(COEF_HALF, '0, '0, 1'b1);
        send_sample(16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd0);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(16'sd0);
    endtask

    // Extreme coefficients drive the recursive state into both rails
    task automatic test_saturation();
        set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, 1'b1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, 1'b1);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sd0);
    endtask

    // Random coefficient sets, each followed by a burst of audio
    task automatic test_random_filters(input int n_items);
        int sent;
        int burst;
        int kind;
        int pick;
        int b2v;
        int lim;
        int b1v;
        int a0v;
        logic signed [SAMPLE_W-1:0] smp;
        sent = 0;
        smp  = '0;
        while (sent < n_items) begin
            kind = $urandom_range(9);
            if (kind <= 5) begin
                // stable two-pole: |b2| < 1, |b1| < 1 - b2
                b2v = -int'($urandom_range(65535));
                lim = 65535 - b2v;
                b1v = int'($urandom_range(2 * lim)) - lim;
                a0v = int'($urandom_range(16384)) - 8192;
                set_coefs(COEF_W'(a0v), COEF_W'(b1v), COEF_W'(b2v),
                          $urandom_range(3) == 0);
            end else if (kind <= 7) begin
                set_coefs(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                          $urandom_range(3) == 0);
            end else begin
                set_coefs(EDGE_COEFS[$urandom_range(6)], EDGE_COEFS[$urandom_range(6)],
                          EDGE_COEFS[$urandom_range(6)], $urandom_range(3) == 0);
            end
            burst = $urandom_range(80, 20);
            repeat (burst) begin
                pick = $urandom_range(9);
                if (pick <= 5) smp = SAMPLE_W'($urandom());
                else if (pick <= 7) smp = SAMPLE_W'(int'($urandom_range(512)) - 256);
                else if (pick == 8) smp = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                // otherwise hold the previous sample (DC step)
                send_sample(smp);
            end
            sent += burst;
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_unity_numerator();
        test_half_rounding();
        test_saturation();
        test_random_filters(640);

        send_idle_pct  = 68;
        recv_stall_pct = 33;
        test_random_filters(640);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_filters(640);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("resonant_lowpass_biquad regression: pass");
        end else begin
            $display("resonant_lowpass_biquad regression: fail");
        end
        $finish;
    end

endmodule

### files.f
rtl/rlb_pkg.sv
rtl/rlb_gain.sv
rtl/rlb_recur.sv
rtl/rlb_outsat.sv
rtl/resonant_lowpass_biquad.sv
test/resonant_lowpass_biquad_tb.sv
